// ===== hdl/e2c_pkg.sv =====
// ----------------------------------------------------------------------------
// e2c_pkg: shared constants, types and functions for the epoch calendar
// Reciprocal constants, inter-module payload types, month-start table and the
// binary to packed-BCD conversion used across the conversion pipeline.
// ----------------------------------------------------------------------------
package e2c_pkg;

	// last second of 2099, counted from 2009-01-01 00:00:00
	localparam logic [31:0] LAST_SECOND = 32'd2871676799;

	// exact reciprocals: floor(x * R / 2^k) == floor(x / d) over the value range
	localparam logic [25:0] DAY_RECIP   = 26'd50903317; // (t >> 7) / 675, k = 35
	localparam logic [15:0] YEAR_RECIP  = 16'd45965;    // days / 365, k = 24
	localparam logic [16:0] WEEK_RECIP  = 17'd74899;    // days / 7, k = 19
	localparam logic [13:0] HOUR_RECIP  = 14'd9321;     // (sod >> 4) / 225, k = 21
	localparam logic [10:0] MIN_RECIP   = 11'd1093;     // (rem >> 2) / 15, k = 14
	localparam logic [9:0]  MONTH_RECIP = 10'd565;      // doy / 29, k = 14
	localparam logic [7:0]  TEN_RECIP   = 8'd205;       // v / 10, k = 11

	localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [2:0]  EPOCH_WDAY    = 3'd4;  // 2009-01-01 is a Thursday
	localparam logic [6:0]  YEAR_BASE     = 7'd9;  // year offset 0 is 2009
	localparam logic [3:0]  LAST_MONTH    = 4'd12;

	// day count and second of day, out of the front end
	typedef struct packed {
		logic [15:0] days;
		logic [16:0] sod;
		logic        flag;
	} e2c_split_t;

	// binary calendar fields, into the BCD stage
	typedef struct packed {
		logic [6:0] yoff;
		logic [3:0] month;
		logic [4:0] mday0;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
		logic       flag;
	} e2c_date_t;

	// days from the start of the year to the start of month m (1..12)
	function automatic logic [8:0] month_begin(input logic [6:0] yoff, input logic [3:0] m);
		logic [3:0] idx;
		logic [8:0] days;
		idx = (m >= 4'd1 && m <= LAST_MONTH) ? m - 4'd1 : 4'd11;
		unique case (idx)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'd59;
			4'd3:    days = 9'd90;
			4'd4:    days = 9'd120;
			4'd5:    days = 9'd151;
			4'd6:    days = 9'd181;
			4'd7:    days = 9'd212;
			4'd8:    days = 9'd243;
			4'd9:    days = 9'd273;
			4'd10:   days = 9'd304;
			default: days = 9'd334;
		endcase
		// leap day from March on, every fourth year from 2012
		if (idx > 4'd1 && yoff[1:0] == 2'b11) begin
			days = days + 9'd1;
		end
		return days;
	endfunction

	// packed BCD of a value below 100
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 15'(v) * 15'(TEN_RECIP);
		tens = prod[14:11];
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

endpackage

// ===== hdl/e2c_day_split.sv =====
// ----------------------------------------------------------------------------
// e2c_day_split: saturate the epoch count and split it into days and seconds
// Three pipeline stages: clamp, day count by reciprocal, second of day.
// ----------------------------------------------------------------------------
module e2c_day_split
	import e2c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output e2c_split_t  out_data
);

	logic        v_s1, v_s2, v_s3;
	logic        adv_s1, adv_s2, adv_s3;
	logic [31:0] t_s1;
	logic        flag_s1, flag_s2, flag_s3;
	logic [15:0] days_s2, days_s3;
	logic [16:0] tlo_s2, sod_s3;
	logic [50:0] day_prod;
	logic [32:0] day_sec;

	// advance a stage when it is empty or its successor moves
	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// day count: t / 86400 == (t >> 7) / 675
	assign day_prod = 51'(t_s1[31:7]) * 51'(DAY_RECIP);
	assign day_sec  = 33'(days_s2) * 33'(SEC_PER_DAY);

	always_ff @(posedge clk) begin
		// clamp past the end of 2099
		if (adv_s1 && in_valid) begin
			t_s1    <= (epoch_seconds > LAST_SECOND) ? LAST_SECOND : epoch_seconds;
			flag_s1 <= epoch_seconds > LAST_SECOND;
		end
		if (adv_s2 && v_s1) begin
			days_s2 <= day_prod[50:35];
			tlo_s2  <= t_s1[16:0];
			flag_s2 <= flag_s1;
		end
		// second of day is below 2^17, so the low bits suffice
		if (adv_s3 && v_s2) begin
			days_s3 <= days_s2;
			sod_s3  <= tlo_s2 - day_sec[16:0];
			flag_s3 <= flag_s2;
		end
	end

	assign out_valid     = v_s3;
	assign out_data.days = days_s3;
	assign out_data.sod  = sod_s3;
	assign out_data.flag = flag_s3;

endmodule

// ===== hdl/e2c_cal_path.sv =====
// ----------------------------------------------------------------------------
// e2c_cal_path: year, month, day, time of day and weekday from the day split
// Six pipeline stages: guess year and hour, check year start, pick year and
// minute, guess month, look up month starts, pick month and day.
// ----------------------------------------------------------------------------
module e2c_cal_path
	import e2c_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  e2c_split_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output e2c_date_t  out_data
);

	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic adv_s4, adv_s5, adv_s6, adv_s7, adv_s8, adv_s9;

	// stage 4
	logic [15:0] days_s4, wkx_s4;
	logic [16:0] sod_s4;
	logic [6:0]  yg_s4;
	logic [12:0] q7_s4;
	logic [4:0]  hour_s4;
	logic        flag_s4;
	// stage 5
	logic [15:0] days_s5, yb0_s5, yb1_s5;
	logic [6:0]  yg_s5;
	logic [2:0]  wday_s5;
	logic [4:0]  hour_s5;
	logic [11:0] rem_s5;
	logic        flag_s5;
	// stage 6
	logic [6:0]  yoff_s6;
	logic [8:0]  doy_s6;
	logic [2:0]  wday_s6;
	logic [4:0]  hour_s6;
	logic [11:0] rem_s6;
	logic [5:0]  min_s6;
	logic        flag_s6;
	// stage 7
	logic [6:0]  yoff_s7;
	logic [8:0]  doy_s7;
	logic [3:0]  mg_s7;
	logic [2:0]  wday_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  min_s7, sec_s7;
	logic        flag_s7;
	// stage 8
	logic [6:0]  yoff_s8;
	logic [8:0]  doy_s8, mb0_s8, mb1_s8;
	logic [3:0]  mg_s8;
	logic [2:0]  wday_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  min_s8, sec_s8;
	logic        flag_s8;
	// stage 9
	e2c_date_t   date_s9;

	logic [31:0] yg_prod;
	logic [15:0] wk_x;
	logic [32:0] wk_prod;
	logic [26:0] hr_prod;
	logic [6:0]  yg_m1;
	logic [15:0] wk_rem;
	logic [16:0] sod_rem;
	logic        late;
	logic [15:0] ydiff;
	logic [20:0] mi_prod;
	logic [18:0] mo_prod;
	logic [3:0]  mg_raw;
	logic [11:0] sec_rem;
	logic        back;
	logic [8:0]  mdiff;

	// advance a stage when it is empty or its successor moves
	assign adv_s9   = !v_s9 || out_ready;
	assign adv_s8   = !v_s8 || adv_s9;
	assign adv_s7   = !v_s7 || adv_s8;
	assign adv_s6   = !v_s6 || adv_s7;
	assign adv_s5   = !v_s5 || adv_s6;
	assign adv_s4   = !v_s4 || adv_s5;
	assign in_ready = adv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (adv_s4) v_s4 <= in_valid;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
			if (adv_s8) v_s8 <= v_s7;
			if (adv_s9) v_s9 <= v_s8;
		end
	end

	// year guess, weekday quotient and hour by reciprocal
	assign yg_prod = 32'(in_data.days) * 32'(YEAR_RECIP);
	assign wk_x    = in_data.days + 16'(EPOCH_WDAY);
	assign wk_prod = 33'(wk_x) * 33'(WEEK_RECIP);
	assign hr_prod = 27'(in_data.sod[16:4]) * 27'(HOUR_RECIP);

	// year start for the guess and the year before it
	assign yg_m1   = yg_s4 - 7'd1;
	assign wk_rem  = wkx_s4 - 16'(q7_s4) * 16'd7;
	assign sod_rem = sod_s4 - 17'(hour_s4) * 17'(SEC_PER_HOUR);

	// step back a year when the guessed year starts after the day count
	assign late    = (yg_s5 != 7'd0) && (yb0_s5 > days_s5);
	assign ydiff   = days_s5 - (late ? yb1_s5 : yb0_s5);
	assign mi_prod = 21'(rem_s5[11:2]) * 21'(MIN_RECIP);

	// month guess from a 29-day month, held at December
	assign mo_prod = 19'(doy_s6) * 19'(MONTH_RECIP);
	assign mg_raw  = mo_prod[17:14] + 4'd1;
	assign sec_rem = rem_s6 - 12'(min_s6) * 12'(SEC_PER_MIN);

	// step back a month when the guessed month starts after the day of year
	assign back  = (mg_s8 > 4'd1) && (mb0_s8 > doy_s8);
	assign mdiff = doy_s8 - (back ? mb1_s8 : mb0_s8);

	always_ff @(posedge clk) begin
		if (adv_s4 && in_valid) begin
			days_s4 <= in_data.days;
			wkx_s4  <= wk_x;
			sod_s4  <= in_data.sod;
			yg_s4   <= yg_prod[30:24];
			q7_s4   <= wk_prod[31:19];
			hour_s4 <= hr_prod[25:21];
			flag_s4 <= in_data.flag;
		end
		if (adv_s5 && v_s4) begin
			days_s5 <= days_s4;
			yg_s5   <= yg_s4;
			yb0_s5  <= 16'(yg_s4) * 16'(DAYS_PER_YEAR) + 16'(yg_s4[6:2]);
			yb1_s5  <= 16'(yg_m1) * 16'(DAYS_PER_YEAR) + 16'(yg_m1[6:2]);
			wday_s5 <= wk_rem[2:0] + 3'd1;
			hour_s5 <= hour_s4;
			rem_s5  <= sod_rem[11:0];
			flag_s5 <= flag_s4;
		end
		if (adv_s6 && v_s5) begin
			yoff_s6 <= late ? yg_s5 - 7'd1 : yg_s5;
			doy_s6  <= ydiff[8:0];
			wday_s6 <= wday_s5;
			hour_s6 <= hour_s5;
			rem_s6  <= rem_s5;
			min_s6  <= mi_prod[19:14];
			flag_s6 <= flag_s5;
		end
		if (adv_s7 && v_s6) begin
			yoff_s7 <= yoff_s6;
			doy_s7  <= doy_s6;
			mg_s7   <= (mg_raw > LAST_MONTH) ? LAST_MONTH : mg_raw;
			wday_s7 <= wday_s6;
			hour_s7 <= hour_s6;
			min_s7  <= min_s6;
			sec_s7  <= sec_rem[5:0];
			flag_s7 <= flag_s6;
		end
		if (adv_s8 && v_s7) begin
			yoff_s8 <= yoff_s7;
			doy_s8  <= doy_s7;
			mg_s8   <= mg_s7;
			mb0_s8  <= month_begin(yoff_s7, mg_s7);
			mb1_s8  <= month_begin(yoff_s7, mg_s7 - 4'd1);
			wday_s8 <= wday_s7;
			hour_s8 <= hour_s7;
			min_s8  <= min_s7;
			sec_s8  <= sec_s7;
			flag_s8 <= flag_s7;
		end
		if (adv_s9 && v_s8) begin
			date_s9.yoff    <= yoff_s8;
			date_s9.month   <= back ? mg_s8 - 4'd1 : mg_s8;
			date_s9.mday0   <= mdiff[4:0];
			date_s9.hour    <= hour_s8;
			date_s9.minute  <= min_s8;
			date_s9.second  <= sec_s8;
			date_s9.weekday <= wday_s8;
			date_s9.flag    <= flag_s8;
		end
	end

	assign out_valid = v_s9;
	assign out_data  = date_s9;

endmodule

// ===== hdl/e2c_bcd_out.sv =====
// ----------------------------------------------------------------------------
// e2c_bcd_out: output register with binary to packed-BCD conversion
// Converts the date and time fields to BCD and holds them until the request is taken.
// ----------------------------------------------------------------------------
module e2c_bcd_out
	import e2c_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  e2c_date_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] year_bcd,
	output logic [4:0] month_bcd,
	output logic [5:0] mday_bcd,
	output logic [5:0] hour_bcd,
	output logic [6:0] minute_bcd,
	output logic [6:0] second_bcd,
	output logic [2:0] weekday,
	output logic       out_of_range
);

	logic       v_s10;
	logic       adv_s10;
	logic [7:0] year_s10;
	logic [7:0] month_w, mday_w, hour_w, minute_w, second_w;
	logic [4:0] month_s10;
	logic [5:0] mday_s10, hour_s10;
	logic [6:0] minute_s10, second_s10;
	logic [2:0] wday_s10;
	logic       flag_s10;

	assign adv_s10  = !v_s10 || out_ready;
	assign in_ready = adv_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv_s10) begin
			v_s10 <= in_valid;
		end
	end

	// convert each field to packed BCD
	assign month_w  = to_bcd(7'(in_data.month));
	assign mday_w   = to_bcd(7'(in_data.mday0) + 7'd1);
	assign hour_w   = to_bcd(7'(in_data.hour));
	assign minute_w = to_bcd(7'(in_data.minute));
	assign second_w = to_bcd(7'(in_data.second));

	always_ff @(posedge clk) begin
		if (adv_s10 && in_valid) begin
			year_s10   <= to_bcd(in_data.yoff + YEAR_BASE);
			month_s10  <= month_w[4:0];
			mday_s10   <= mday_w[5:0];
			hour_s10   <= hour_w[5:0];
			minute_s10 <= minute_w[6:0];
			second_s10 <= second_w[6:0];
			wday_s10   <= in_data.weekday;
			flag_s10   <= in_data.flag;
		end
	end

	assign out_valid    = v_s10;
	assign year_bcd     = year_s10;
	assign month_bcd    = month_s10;
	assign mday_bcd     = mday_s10;
	assign hour_bcd     = hour_s10;
	assign minute_bcd   = minute_s10;
	assign second_bcd   = second_s10;
	assign weekday      = wday_s10;
	assign out_of_range = flag_s10;

endmodule

// ===== hdl/epoch_seconds_to_bcd_calendar.sv =====
// Throughput: one request per cycle with out_ready high; ten pipeline stages,
// each with its own valid bit; a stage moves when empty or its successor moves.
// Stall: out_ready low holds the result and each full stage with no empty stage
// after it; in_ready falls only when all ten stages are full and out_ready is
// low. Reset clears the valid bits; data registers keep whatever they hold.
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_calendar: seconds since 2009 to packed-BCD calendar
// Splits the count into days and seconds, finds year, month, day, time of
// day and weekday, and registers the fields in packed BCD.
// ----------------------------------------------------------------------------
module epoch_seconds_to_bcd_calendar
	import e2c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  year_bcd,
	output logic [4:0]  month_bcd,
	output logic [5:0]  mday_bcd,
	output logic [5:0]  hour_bcd,
	output logic [6:0]  minute_bcd,
	output logic [6:0]  second_bcd,
	output logic [2:0]  weekday,
	output logic        out_of_range
);

	e2c_split_t split;
	logic       split_valid, split_ready;
	e2c_date_t  date;
	logic       date_valid, date_ready;

	// day count and second of day
	e2c_day_split u_day_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.epoch_seconds (epoch_seconds),
		.out_valid     (split_valid),
		.out_ready     (split_ready),
		.out_data      (split)
	);

	// calendar fields in binary
	e2c_cal_path u_cal_path (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_data   (split),
		.out_valid (date_valid),
		.out_ready (date_ready),
		.out_data  (date)
	);

	// packed BCD output register
	e2c_bcd_out u_bcd_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (date_valid),
		.in_ready     (date_ready),
		.in_data      (date),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year_bcd     (year_bcd),
		.month_bcd    (month_bcd),
		.mday_bcd     (mday_bcd),
		.hour_bcd     (hour_bcd),
		.minute_bcd   (minute_bcd),
		.second_bcd   (second_bcd),
		.weekday      (weekday),
		.out_of_range (out_of_range)
	);

endmodule

// ===== hdl/e2c_checker.sv =====
// ----------------------------------------------------------------------------
// e2c_checker: port-level checks for the epoch calendar
// Watches the result channel for held requests, saturation and field ranges.
// ----------------------------------------------------------------------------
module e2c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  year_bcd,
	input logic [4:0]  month_bcd,
	input logic [5:0]  mday_bcd,
	input logic [5:0]  hour_bcd,
	input logic [6:0]  minute_bcd,
	input logic [6:0]  second_bcd,
	input logic [2:0]  weekday,
	input logic        out_of_range
);

	// hold a stalled result request
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	// a saturated input gives the last second of 2099, a Thursday
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> year_bcd == 8'h99 && month_bcd == 5'h12 &&
			mday_bcd == 6'h31 && hour_bcd == 6'h23 && minute_bcd == 7'h59 &&
			second_bcd == 7'h59 && weekday == 3'd5)
		else $error("saturated result is not 2099-12-31 23:59:59");

	// weekday runs from Sunday (1) to Saturday (7)
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weekday != 3'd0)
		else $error("weekday zero on a result");

	// month never leaves 01..12, late December included
	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month_bcd != 5'h00 && month_bcd <= 5'h12 && month_bcd[3:0] <= 4'd9)
		else $error("month outside 01..12");

endmodule

bind epoch_seconds_to_bcd_calendar e2c_checker u_e2c_checker (.*);

// ===== test/epoch_seconds_to_bcd_calendar_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_calendar_tb: self-checking bench for the epoch calendar
// Feeds epoch second counts through the valid/ready request channel, predicts
// the packed-BCD date, time, weekday and saturation flag for every accepted
// request, and compares each result in order while both sides stall at random.
// ----------------------------------------------------------------------------
module epoch_seconds_to_bcd_calendar_tb;

	localparam int unsigned SECS_MIN    = 60;
	localparam int unsigned SECS_HOUR   = 3600;
	localparam int unsigned SECS_DAY    = 86400;
	localparam int unsigned SECS_YEAR   = 365 * SECS_DAY;
	localparam int unsigned END_OF_2099 = 32'd2871676799;
	localparam int unsigned RANDOM_REQS = 1825;
	localparam int          IDLE_PCT    = 23;
	localparam int          CALM_FROM   = 1200;
	localparam int          CALM_TO     = 1700;
	localparam int          HOLD_START  = 300;
	localparam int          HOLD_LEN    = 60;
	localparam int          DRAIN_WAIT  = 20;
	localparam int          CYCLE_LIMIT = 60000;

	// day of year on which each month begins, common year
	localparam int unsigned MONTH_FIRST_DAY [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	typedef struct packed {
		logic [7:0] year;
		logic [4:0] month;
		logic [5:0] mday;
		logic [5:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [2:0] wday;
		logic       sat;
	} calendar_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] epoch_seconds = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  year_bcd;
	logic [4:0]  month_bcd;
	logic [5:0]  mday_bcd;
	logic [5:0]  hour_bcd;
	logic [6:0]  minute_bcd;
	logic [6:0]  second_bcd;
	logic [2:0]  weekday;
	logic        out_of_range;

	logic [31:0] pending_epochs [$];
	calendar_t   expected_dates [$];
	calendar_t   head_date;
	logic        req_taken = 1'b0;
	logic        calm;
	int          cycle_count = 0;
	int          rx_cycles = 0;
	int          hold_left = 0;
	int          epochs_total = 0;
	int          epochs_accepted = 0;
	int          mismatches = 0;

	epoch_seconds_to_bcd_calendar u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year_bcd     (year_bcd),
		.month_bcd    (month_bcd),
		.mday_bcd     (mday_bcd),
		.hour_bcd     (hour_bcd),
		.minute_bcd   (minute_bcd),
		.second_bcd   (second_bcd),
		.weekday      (weekday),
		.out_of_range (out_of_range)
	);

	// no idling on either side inside this window
	assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

	function automatic logic [7:0] bcd2(int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// seconds from 2009-01-01 to the start of year 2009 + yoff
	function automatic int unsigned year_start(int unsigned yoff);
		return yoff * SECS_YEAR + (yoff / 4) * SECS_DAY;
	endfunction

	// seconds from the start of the year to the start of month m, leap day from March
	function automatic int unsigned month_start(int unsigned yoff, int unsigned m);
		int unsigned days;
		days = MONTH_FIRST_DAY[m - 1];
		if (m > 2 && (yoff % 4) == 3) begin
			days = days + 1;
		end
		return days * SECS_DAY;
	endfunction

	// predict the calendar fields of one epoch count
	function automatic calendar_t calendar_of(logic [31:0] secs);
		int unsigned t, yoff, ystart, mon, mstart, d, h, mi;
		calendar_t c;
		t = secs;
		c.sat = (t > END_OF_2099);
		if (c.sat) begin
			t = END_OF_2099;
		end
		c.wday = 3'((4 + t / SECS_DAY) % 7 + 1);
		// guess the year, step back if it begins after the count
		yoff = t / SECS_YEAR;
		ystart = year_start(yoff);
		if (ystart > t && yoff > 0) begin
			yoff = yoff - 1;
			ystart = year_start(yoff);
		end
		t = t - ystart;
		// guess the month from a 29-day month, clamp to December, step back if late
		mon = t / (29 * SECS_DAY) + 1;
		if (mon > 12) begin
			mon = 12;
		end
		mstart = month_start(yoff, mon);
		if (mstart > t && mon > 1) begin
			mon = mon - 1;
			mstart = month_start(yoff, mon);
		end
		t = t - mstart;
		d = t / SECS_DAY;
		t = t - d * SECS_DAY;
		h = t / SECS_HOUR;
		t = t - h * SECS_HOUR;
		mi = t / SECS_MIN;
		t = t - mi * SECS_MIN;
		c.year   = bcd2(yoff + 9);
		c.month  = 5'(bcd2(mon));
		c.mday   = 6'(bcd2(d + 1));
		c.hour   = 6'(bcd2(h));
		c.minute = 7'(bcd2(mi));
		c.second = 7'(bcd2(t));
		return c;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// build the request list, release reset, wait for the drain, report
	initial begin
		int unsigned base, pick, yoff;
		pending_epochs = '{
			32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			32'd2678399, 32'd2678400, 32'd31535999, 32'd31536000,
			32'd99705600, 32'd99791999, 32'd99792000, 32'd125238896,
			32'd126230399, 32'd126230400, 32'h5555_5555, 32'hAAAA_AAAA,
			END_OF_2099 - 1, END_OF_2099, END_OF_2099 + 1,
			32'h8000_0000, 32'hFFFF_FFFF
		};
		for (int i = 0; i < RANDOM_REQS; i++) begin
			pick = $urandom_range(99);
			yoff = $urandom_range(91);
			if (pick < 45) begin
				// anywhere in the calendar
				pending_epochs.push_back($urandom_range(END_OF_2099, 0));
			end else if (pick < 60) begin
				// any bit pattern, about a third of them past the end
				pending_epochs.push_back($urandom);
			end else if (pick < 80) begin
				// around a month start, either side of any leap shift
				base = year_start(yoff) + MONTH_FIRST_DAY[$urandom_range(11)] * SECS_DAY
					+ $urandom_range(1) * SECS_DAY;
				if (base >= 2 * SECS_DAY) begin
					base = base - 2 * SECS_DAY;
				end
				pending_epochs.push_back(base + $urandom_range(4 * SECS_DAY - 1));
			end else if (pick < 93) begin
				// late December, where the month guess overshoots
				pending_epochs.push_back(year_start(yoff)
					+ $urandom_range(366 * SECS_DAY - 1, 348 * SECS_DAY));
			end else begin
				// close to the last second of 2099
				pending_epochs.push_back(END_OF_2099 - 300 + $urandom_range(600));
			end
		end
		epochs_total = pending_epochs.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (epochs_accepted != epochs_total || expected_dates.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// end the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(negedge clk);
		end
		$display("Some tests failed");
		$finish;
	end

	// offer the next request once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (pending_epochs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				epoch_seconds <= pending_epochs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// drive out_ready: random stalls, one long hold-off to fill the pipeline
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycles <= rx_cycles + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (rx_cycles == HOLD_START) begin
				hold_left <= HOLD_LEN;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// record accepted requests, check each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			req_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				expected_dates.push_back(calendar_of(epoch_seconds));
				epochs_accepted <= epochs_accepted + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					head_date = expected_dates.pop_front();
					check_field("year_bcd", head_date.year, year_bcd);
					check_field("month_bcd", head_date.month, month_bcd);
					check_field("mday_bcd", head_date.mday, mday_bcd);
					check_field("hour_bcd", head_date.hour, hour_bcd);
					check_field("minute_bcd", head_date.minute, minute_bcd);
					check_field("second_bcd", head_date.second, second_bcd);
					check_field("weekday", head_date.wday, weekday);
					check_field("out_of_range", head_date.sat, out_of_range);
				end
			end
		end
	end

endmodule

// ===== files.f =====
hdl/e2c_pkg.sv
hdl/e2c_day_split.sv
hdl/e2c_cal_path.sv
hdl/e2c_bcd_out.sv
hdl/epoch_seconds_to_bcd_calendar.sv
hdl/e2c_checker.sv
test/epoch_seconds_to_bcd_calendar_tb.sv
